// ===== hw/rtl/mrhp_pkg.sv =====
// Package with the types and constants shared by the holding-register response parser.
package mrhp_pkg;

   // Function codes seen in byte 1 of the response.
   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FUNC_EXCEPTION_FLAG = 8'h80;
   localparam logic [7:0] FUNC_EXCEPTION = FUNC_READ_HOLDING | FUNC_EXCEPTION_FLAG;

   // Header length: slave address, function code, byte count.
   localparam logic [8:0] HEADER_BYTES = 9'd3;
   localparam logic [8:0] POS_LIMIT = 9'd511;

   // Configuration register indexes.
   localparam logic CSR_EXPECTED_SLAVE = 1'b0;
   localparam logic CSR_EXPECTED_QUANTITY = 1'b1;

   // Result kinds.
   localparam logic KIND_REGISTER = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Class of the function code byte.
   typedef enum logic [1:0] {
      FCLASS_NORMAL = 2'd0,
      FCLASS_EXCEPTION = 2'd1,
      FCLASS_OTHER = 2'd2
   } fclass_type;

   // Frame status codes.
   typedef enum logic [2:0] {
      STATUS_OK = 3'd0,
      STATUS_INVALID_ARG = 3'd1,
      STATUS_LENGTH_ERROR = 3'd2,
      STATUS_SLAVE_MISMATCH = 3'd3,
      STATUS_EXCEPTION = 3'd4,
      STATUS_FUNCTION_ERROR = 3'd5
   } status_type;

   // One result word.
   typedef struct packed {
      logic        result_kind;
      logic [6:0]  reg_index;
      logic [15:0] reg_value;
      logic [2:0]  frame_status;
      logic [7:0]  exception_code;
      logic        frame_done;
   } result_type;

   // Up to two result words written into the queue in one cycle.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== hw/rtl/mrhp_parser.sv =====
// Input register, frame state and per-byte result logic of the response parser.
module mrhp_parser #(
   parameter int MAX_QUANTITY = 125
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_byte,
   input  logic                req_last,
   input  logic                queue_room,
   output mrhp_pkg::push_type  push
);
   import mrhp_pkg::*;

   localparam logic [6:0] MAX_Q = 7'(MAX_QUANTITY);

   logic [7:0] expected_slave_ff;
   logic [6:0] expected_quantity_ff;

   logic       stage_valid_ff;
   logic [7:0] stage_byte_ff;
   logic       stage_last_ff;

   logic [8:0] byte_position_ff, byte_position_in;
   logic       slave_matched_ff, slave_matched_in;
   fclass_type function_class_ff, function_class_in;
   logic       count_matched_ff, count_matched_in;
   logic [7:0] held_exception_ff, held_exception_in;
   logic [7:0] high_byte_hold_ff, high_byte_hold_in;

   logic       fire;
   logic       quantity_ok;
   logic [7:0] want_bytes;
   logic [8:0] body_pos;
   logic [7:0] pair_index;
   logic       emit_reg;
   logic [8:0] final_pos;
   status_type status;
   logic [7:0] exc_code;
   result_type reg_result;
   result_type status_result;

   // The staged byte moves on when the queue can take two words.
   assign fire = stage_valid_ff && queue_room;
   assign req_tready = !stage_valid_ff || queue_room;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_slave_ff <= 8'd1;
         expected_quantity_ff <= 7'd1;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_EXPECTED_SLAVE: expected_slave_ff <= csr_wdata;
            CSR_EXPECTED_QUANTITY: expected_quantity_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         stage_valid_ff <= 1'b1;
      end else if (fire) begin
         stage_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         stage_byte_ff <= req_byte;
         stage_last_ff <= req_last;
      end
   end

   assign quantity_ok = (expected_quantity_ff != 7'd0) && (expected_quantity_ff <= MAX_Q);
   assign want_bytes = {expected_quantity_ff, 1'b0};
   assign body_pos = byte_position_ff - HEADER_BYTES;
   assign pair_index = body_pos[8:1];

   // Header checks and register assembly for the staged byte.
   always_comb begin
      slave_matched_in = slave_matched_ff;
      function_class_in = function_class_ff;
      count_matched_in = count_matched_ff;
      held_exception_in = held_exception_ff;
      high_byte_hold_in = high_byte_hold_ff;
      emit_reg = 1'b0;
      case (byte_position_ff)
         9'd0: slave_matched_in = (stage_byte_ff == expected_slave_ff);
         9'd1: begin
            if (stage_byte_ff == FUNC_READ_HOLDING) begin
               function_class_in = FCLASS_NORMAL;
            end else if (stage_byte_ff == FUNC_EXCEPTION) begin
               function_class_in = FCLASS_EXCEPTION;
            end else begin
               function_class_in = FCLASS_OTHER;
            end
         end
         9'd2: begin
            count_matched_in = (stage_byte_ff == want_bytes);
            held_exception_in = stage_byte_ff;
         end
         default: begin
            if (!body_pos[0]) begin
               high_byte_hold_in = stage_byte_ff;
            end else begin
               emit_reg = quantity_ok && slave_matched_ff &&
                          (function_class_ff == FCLASS_NORMAL) && count_matched_ff &&
                          (pair_index < {1'b0, expected_quantity_ff});
            end
         end
      endcase
   end

   // Frame status in priority order, taken with this byte's header updates.
   assign final_pos = {1'b0, expected_quantity_ff, 1'b0} + 9'd2;

   always_comb begin
      exc_code = 8'd0;
      if (!quantity_ok) begin
         status = STATUS_INVALID_ARG;
      end else if (byte_position_ff < 9'd2) begin
         status = STATUS_LENGTH_ERROR;
      end else if (!slave_matched_in) begin
         status = STATUS_SLAVE_MISMATCH;
      end else if (function_class_in == FCLASS_EXCEPTION) begin
         status = STATUS_EXCEPTION;
         exc_code = held_exception_in;
      end else if (function_class_in != FCLASS_NORMAL) begin
         status = STATUS_FUNCTION_ERROR;
      end else if (!count_matched_in || (byte_position_ff != final_pos)) begin
         status = STATUS_LENGTH_ERROR;
      end else begin
         status = STATUS_OK;
      end
   end

   // Result words for the queue.
   always_comb begin
      reg_result.result_kind = KIND_REGISTER;
      reg_result.reg_index = pair_index[6:0];
      reg_result.reg_value = {high_byte_hold_ff, stage_byte_ff};
      reg_result.frame_status = 3'd0;
      reg_result.exception_code = 8'd0;
      reg_result.frame_done = 1'b0;

      status_result.result_kind = KIND_STATUS;
      status_result.reg_index = 7'd0;
      status_result.reg_value = 16'd0;
      status_result.frame_status = status;
      status_result.exception_code = exc_code;
      status_result.frame_done = 1'b1;

      push.first = emit_reg ? reg_result : status_result;
      push.second = status_result;
      push.count = 2'd0;
      if (fire) begin
         push.count = {1'b0, emit_reg} + {1'b0, stage_last_ff};
      end
   end

   // Position counter, saturating at its limit.
   always_comb begin
      byte_position_in = byte_position_ff;
      if (byte_position_ff < POS_LIMIT) begin
         byte_position_in = byte_position_ff + 9'd1;
      end
   end

   // Frame state; the last byte returns everything to zero.
   always_ff @(posedge clock) begin
      if (reset || (fire && stage_last_ff)) begin
         byte_position_ff <= 9'd0;
         slave_matched_ff <= 1'b0;
         function_class_ff <= FCLASS_NORMAL;
         count_matched_ff <= 1'b0;
         held_exception_ff <= 8'd0;
         high_byte_hold_ff <= 8'd0;
      end else if (fire) begin
         byte_position_ff <= byte_position_in;
         slave_matched_ff <= slave_matched_in;
         function_class_ff <= function_class_in;
         count_matched_ff <= count_matched_in;
         held_exception_ff <= held_exception_in;
         high_byte_hold_ff <= high_byte_hold_in;
      end
   end

endmodule

// ===== hw/rtl/mrhp_result_queue.sv =====
// Four-word result queue that takes up to two words a cycle and gives one.
module mrhp_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  mrhp_pkg::push_type    push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mrhp_pkg::result_type  rsp_word
);
   import mrhp_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   // Room means two free words, counted before this cycle's pop.
   assign room = count_ff <= (PTR_W+1)'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_word = entry_ff[rd_ptr_ff];
   assign pop = rsp_valid && rsp_ready;
   assign wr_next = wr_ptr_ff + PTR_W'(1);
   assign count_in = count_ff + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);

   // Storage writes at the write pointer and the one after it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(DEPTH))
      else $error("result queue count exceeds its depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("result queue written without room");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - (PTR_W+1)'(1)))
      else $error("result queue count did not drop after a pop");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0])
      else $error("result queue pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/modbus_read_holding_response_parser.sv =====
// Top level of the holding-register response parser: byte stream in, results out.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/tready      tdata = data_byte, tlast = end_of_frame
//   rsp_      out        rsp_tvalid/tready      tdata = index/value/status/exception,
//                                               tuser = result_kind, tlast = frame_done
//   csr_      in         csr_wen                csr_index, csr_wdata
//
// One byte is taken every cycle; a byte waits in the input register and its results go into
// the result queue, which drives the output. The four-word result queue sets the rate:
// a byte moves on only while two words are free, so a stalled output holds the input.
// A byte can give a register word and a status word; they leave one per cycle.
// Reset is synchronous and restores the configuration defaults and an empty frame.
module modbus_read_holding_response_parser #(
   parameter int MAX_QUANTITY = 125
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [6:0] reg_index, [22:7] reg_value,
                                    // [25:23] frame_status, [33:26] exception_code, zeros
   output logic        rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast
);
   import mrhp_pkg::*;

   push_type   push;
   logic       queue_room;
   result_type rsp_word;

   mrhp_parser #(
      .MAX_QUANTITY(MAX_QUANTITY)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_byte(req_tdata),
      .req_last(req_tlast),
      .queue_room(queue_room),
      .push(push)
   );

   mrhp_result_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(queue_room),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_word(rsp_word)
   );

   // Pack the result word onto the output bus.
   assign rsp_tdata = {6'd0, rsp_word.exception_code, rsp_word.frame_status,
                       rsp_word.reg_value, rsp_word.reg_index};
   assign rsp_tuser = rsp_word.result_kind;
   assign rsp_tlast = rsp_word.frame_done;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the holding-register response parser.
`timescale 1ns / 1ps

module tb_top;
   import mrhp_pkg::*;

   localparam int MAX_QUANTITY = 125;
   localparam int LONG_STALL = 150;
   localparam int SETTLE_CYCLES = 6;

   // One byte of a response frame as the sender offers it.
   typedef struct packed {
      logic [7:0] data;
      logic       eof;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [6:0] reg_index, [22:7] reg_value,
                                     // [25:23] frame_status, [33:26] exception_code, zeros
   logic        rsp_tuser;           // [0] result_kind
   logic        rsp_tlast;

   modbus_read_holding_response_parser #(
      .MAX_QUANTITY(MAX_QUANTITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bytes waiting to be offered and result words still owed by the block.
   frame_byte_type pending_bytes[$];
   result_type     awaited_words[$];
   frame_byte_type next_byte;

   // Shadow of the configuration and of the frame state inside the block.
   logic [7:0] cfg_slave = 8'd1;
   logic [6:0] cfg_quantity = 7'd1;
   logic [8:0] frame_pos = '0;
   logic       slave_ok = 1'b0;
   fclass_type func_class = FCLASS_NORMAL;
   logic       count_ok = 1'b0;
   logic [7:0] held_exc = '0;
   logic [7:0] high_byte = '0;

   int sender_idle_pct = 19;
   int receiver_idle_pct = 51;
   int stall_requests = 0;
   int stall_served = 0;
   int stall_left = 0;
   int mismatches = 0;
   int bytes_planned = 0;
   int bytes_accepted = 0;
   int frames_accepted = 0;
   int register_words = 0;
   int status_words = 0;
   int settings_used = 0;

   // Update the frame state with one accepted byte and queue the words it owes.
   task automatic parse_byte(input logic [7:0] b, input logic eof);
      logic [8:0] pos;
      logic [8:0] k;
      logic       qty_valid;
      result_type word;
      pos = frame_pos;
      qty_valid = (cfg_quantity != 0) && (int'(cfg_quantity) <= MAX_QUANTITY);
      if (pos == 9'd0) begin
         slave_ok = (b == cfg_slave);
      end else if (pos == 9'd1) begin
         if (b == FUNC_READ_HOLDING) begin
            func_class = FCLASS_NORMAL;
         end else if (b == FUNC_EXCEPTION) begin
            func_class = FCLASS_EXCEPTION;
         end else begin
            func_class = FCLASS_OTHER;
         end
      end else if (pos == 9'd2) begin
         count_ok = (b == {cfg_quantity, 1'b0});
         held_exc = b;
      end else begin
         k = pos - HEADER_BYTES;
         if (!k[0]) begin
            high_byte = b;
         end else if (qty_valid && slave_ok && func_class == FCLASS_NORMAL && count_ok &&
                      (k >> 1) < {2'b00, cfg_quantity}) begin
            word = '0;
            word.result_kind = KIND_REGISTER;
            word.reg_index = k[7:1];
            word.reg_value = {high_byte, b};
            awaited_words.push_back(word);
         end
      end
      if (pos < POS_LIMIT) begin
         frame_pos = pos + 9'd1;
      end

      // The status word follows any register word of the last byte.
      if (eof) begin
         word = '0;
         word.result_kind = KIND_STATUS;
         word.frame_done = 1'b1;
         if (!qty_valid) begin
            word.frame_status = STATUS_INVALID_ARG;
         end else if (pos < 9'd2) begin
            word.frame_status = STATUS_LENGTH_ERROR;
         end else if (!slave_ok) begin
            word.frame_status = STATUS_SLAVE_MISMATCH;
         end else if (func_class == FCLASS_EXCEPTION) begin
            word.frame_status = STATUS_EXCEPTION;
            word.exception_code = held_exc;
         end else if (func_class != FCLASS_NORMAL) begin
            word.frame_status = STATUS_FUNCTION_ERROR;
         end else if (!count_ok || int'(pos) != 2 + 2 * int'(cfg_quantity)) begin
            word.frame_status = STATUS_LENGTH_ERROR;
         end else begin
            word.frame_status = STATUS_OK;
         end
         awaited_words.push_back(word);
         frame_pos = '0;
         slave_ok = 1'b0;
         func_class = FCLASS_NORMAL;
         count_ok = 1'b0;
         held_exc = '0;
         high_byte = '0;
      end
   endtask

   // Sender: offer queued bytes, holding each one until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tlast);
            bytes_accepted++;
            if (req_tlast) begin
               frames_accepted++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && int'($urandom_range(99)) >= sender_idle_pct) begin
               next_byte = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_byte.data;
               req_tlast <= next_byte.eof;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each taken word against the oldest one owed, then pick the next ready.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.result_kind = rsp_tuser;
            got.reg_index = rsp_tdata[6:0];
            got.reg_value = rsp_tdata[22:7];
            got.frame_status = rsp_tdata[25:23];
            got.exception_code = rsp_tdata[33:26];
            got.frame_done = rsp_tlast;
            if (got.result_kind == KIND_STATUS) begin
               status_words++;
            end else begin
               register_words++;
            end
            if (awaited_words.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: word with none owed (kind idx value status exc done)",
                           $time);
                  $display("   actual   %0b %0d %h %0d %h %0b", got.result_kind,
                           got.reg_index, got.reg_value, got.frame_status,
                           got.exception_code, got.frame_done);
               end
               mismatches++;
            end else begin
               want = awaited_words.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("%0t: word mismatch (kind idx value status exc done)", $time);
                     $display("   expected %0b %0d %h %0d %h %0b", want.result_kind,
                              want.reg_index, want.reg_value, want.frame_status,
                              want.exception_code, want.frame_done);
                     $display("   actual   %0b %0d %h %0d %h %0b", got.result_kind,
                              got.reg_index, got.reg_value, got.frame_status,
                              got.exception_code, got.frame_done);
                  end
                  mismatches++;
               end
            end
         end
         if (stall_requests != stall_served) begin
            stall_served++;
            stall_left = LONG_STALL;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (int'($urandom_range(99)) >= receiver_idle_pct);
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic eof);
      pending_bytes.push_back('{data: b, eof: eof});
      bytes_planned++;
   endtask

   // A frame of len bytes: given header bytes, random payload, end mark on the last.
   task automatic add_frame(input logic [7:0] slave, input logic [7:0] func,
                            input logic [7:0] count, input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = (i == 0) ? slave : (i == 1) ? func : (i == 2) ? count : 8'($urandom);
         push_byte(b, i == len - 1);
      end
   endtask

   // Mostly well-formed frames for the current setting, with some broken ones and noise.
   task automatic add_random_frame();
      int unsigned pick;
      int          nregs;
      logic [7:0]  slave;
      logic [7:0]  func;
      logic [7:0]  count;
      int          len;
      pick = $urandom_range(99);
      nregs = (cfg_quantity <= 8) ? int'(cfg_quantity) : int'($urandom_range(3));
      slave = cfg_slave;
      func = FUNC_READ_HOLDING;
      count = {cfg_quantity, 1'b0};
      len = 3 + 2 * nregs;
      if (pick < 60) begin
         len = 3 + 2 * nregs;
      end else if (pick < 66) begin
         slave = 8'($urandom);
      end else if (pick < 72) begin
         func = FUNC_EXCEPTION;
         count = 8'($urandom);
         len = 3 + int'($urandom_range(2));
      end else if (pick < 76) begin
         func = 8'($urandom);
      end else if (pick < 80) begin
         count = 8'($urandom);
      end else if (pick < 90) begin
         len = $urandom_range(1, 6 + 2 * nregs);
      end else begin
         slave = 8'($urandom);
         func = 8'($urandom);
         count = 8'($urandom);
         len = $urandom_range(1, 8);
      end
      add_frame(slave, func, count, len);
   endtask

   // Wait until every queued byte is taken, every owed word has come and the block has settled.
   task automatic drain();
      while (pending_bytes.size() != 0 || req_tvalid || awaited_words.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_EXPECTED_SLAVE) begin
         cfg_slave = value;
      end else begin
         cfg_quantity = value[6:0];
      end
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // Stimulus: directed frames at the reset setting, then random phases.
   initial begin
      logic [7:0] slave;
      logic [7:0] qty;
      int         start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      settings_used = 1;

      // Frame with all-ones data plus one extra pair that must stay silent; it ends in a length error.
      push_byte(8'h01, 1'b0);
      push_byte(FUNC_READ_HOLDING, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);
      // Exception reply, other function code, wrong slave.
      add_frame(8'h01, FUNC_EXCEPTION, 8'h0B, 3);
      add_frame(8'h01, 8'h04, 8'h02, 3);
      add_frame(8'h07, FUNC_READ_HOLDING, 8'h02, 3);
      // Frames too short for a header, and a wrong byte count.
      add_frame(8'h01, 8'h00, 8'h00, 1);
      add_frame(8'h01, FUNC_READ_HOLDING, 8'h00, 2);
      add_frame(8'h01, FUNC_READ_HOLDING, 8'h04, 3);
      // Start a frame, change the setting while it is open, then finish it.
      push_byte(8'h05, 1'b0);
      push_byte(FUNC_READ_HOLDING, 1'b0);
      drain();
      write_csr(CSR_EXPECTED_SLAVE, 8'h05);
      write_csr(CSR_EXPECTED_QUANTITY, 8'd2);
      settings_used++;
      add_frame(8'h04, 8'hFF, 8'h00, 5);

      for (int p = 0; p < 9; p++) begin
         drain();
         if (p / 3 == 0) begin
            sender_idle_pct = 19;
            receiver_idle_pct = 51;
         end else if (p / 3 == 1) begin
            sender_idle_pct = 51;
            receiver_idle_pct = 19;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         slave = 8'($urandom);
         case (p)
            0: begin
               slave = 8'h00;
               qty = 8'($urandom_range(1, 4));
            end
            1: begin
               slave = 8'hFF;
               qty = 8'd125;
            end
            2: qty = 8'd0;
            4: qty = 8'hFF;
            7: qty = 8'd126;
            default: qty = 8'($urandom_range(1, 6));
         endcase
         write_csr(CSR_EXPECTED_SLAVE, slave);
         write_csr(CSR_EXPECTED_QUANTITY, qty);
         settings_used++;
         if (p == 1) begin
            // A frame long enough to saturate the byte counter, under a long output stall.
            stall_requests++;
            add_frame(cfg_slave, FUNC_READ_HOLDING, {cfg_quantity, 1'b0}, 515);
            add_random_frame();
         end else begin
            start = bytes_planned;
            while (bytes_planned - start < 16) begin
               add_random_frame();
            end
         end
      end

      drain();
      $display("Covered %0d bytes in %0d frames over %0d settings,", bytes_accepted,
               frames_accepted, settings_used);
      $display("%0d register and %0d status words, invalid quantities, a saturated",
               register_words, status_words);
      $display("long frame and a long output stall.");
      if (mismatches == 0 && awaited_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mrhp_pkg.sv
hw/rtl/mrhp_parser.sv
hw/rtl/mrhp_result_queue.sv
hw/rtl/modbus_read_holding_response_parser.sv
tb/tb_top.sv
